// ===== src/lfptc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfptc_pkg: shared types and constants
// Verdict codes, request codes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package lfptc_pkg;

	localparam int DEF_STORE_DEPTH = 1024;
	localparam int DEF_VALUE_BITS  = 32;
	localparam int IN_VALUE_BITS   = 32;

	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd0;
	localparam logic [2:0] VERDICT_STACK      = 3'd1;
	localparam logic [2:0] VERDICT_QUEUE      = 3'd2;
	localparam logic [2:0] VERDICT_PRIO       = 3'd3;
	localparam logic [2:0] VERDICT_NOT_SURE   = 3'd4;

	// commands from controller to datapath
	typedef struct packed {
		logic load;        // latch input item
		logic push_wr;     // write key into lifo/fifo, bump counts
		logic pop_chk;     // advance fifo head
		logic pop_empty;   // pop on empty stores
		logic heap_rd_up;  // issue heap read at parent of cursor
		logic heap_up_step;// compare parent, move down or stop
		logic heap_pop_start; // check top, fetch last entry
		logic heap_rd_kids;// read left or right child in turn
		logic heap_dn_step;// compare children, move up or stop
		logic heap_place;  // write held key at cursor
		logic clear;       // clear case
	} lfptc_cmd_t;

	// status back to controller
	typedef struct packed {
		logic [1:0] req;
		logic       full;
		logic       empty;
		logic       up_done;   // cursor at root or parent >= key
		logic       dn_done;   // no child beats key
		logic       heap_last; // heap becomes empty on this pop
	} lfptc_sts_t;

	function automatic logic [2:0] verdict_of(input logic l, input logic f, input logic h);
		logic [2:0] v;
		if (!l && !f && !h)      v = VERDICT_IMPOSSIBLE;
		else if (l && !f && !h)  v = VERDICT_STACK;
		else if (!l && f && !h)  v = VERDICT_QUEUE;
		else if (!l && !f && h)  v = VERDICT_PRIO;
		else                     v = VERDICT_NOT_SURE;
		return v;
	endfunction

endpackage

// ===== src/lfptc_ram.sv =====
// ----------------------------------------------------------------------------
// lfptc_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lfptc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== src/lfptc_datapath.sv =====
// ----------------------------------------------------------------------------
// lfptc_datapath: stores, pointers and flags
// Holds the three RAMs, counts, heap cursor and consistency flags.
// ----------------------------------------------------------------------------
module lfptc_datapath #(
	parameter int STORE_DEPTH = 1024,
	parameter int VALUE_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           req_type,
	input  logic signed [lfptc_pkg::IN_VALUE_BITS-1:0] value,
	input  lfptc_pkg::lfptc_cmd_t cmd,
	output lfptc_pkg::lfptc_sts_t sts,
	output logic [2:0]           verdict,
	output logic                 overflowed
);
	import lfptc_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic [1:0]            req_q;
	logic [VALUE_BITS-1:0] key_q;   // input key, sign flipped
	logic [VALUE_BITS-1:0] hold_q;  // key being sifted
	logic [CW-1:0]         cnt_q;
	logic [AW-1:0]         head_q, tail_q;
	logic [CW-1:0]         cur_q;   // heap cursor, zero between transactions
	logic [CW-1:0]         hcnt_q;  // heap size during sift
	logic                  may_l_q, may_f_q, may_h_q, ovf_q;
	logic [VALUE_BITS-1:0] kid_a_q; // left child value latched
	logic                  kid_phase_q;
	logic                  hold_load_q; // last heap entry on read data

	// lifo / fifo / heap RAMs
	logic [AW-1:0]         l_addr, f_addr, h_addr;
	logic                  l_we, f_we, h_we;
	logic [VALUE_BITS-1:0] l_rd, f_rd, h_rd, h_wd;

	lfptc_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_lifo (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(key_q), .rdata(l_rd));
	lfptc_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_fifo (
		.clk(clk), .we(f_we), .addr(f_addr), .wdata(key_q), .rdata(f_rd));
	lfptc_ram #(.WIDTH(VALUE_BITS), .DEPTH(STORE_DEPTH)) u_heap (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));

	// sign-extend, keep VALUE_BITS, flip sign bit for unsigned ordering
	logic [63:0]           value_ext;
	logic [VALUE_BITS-1:0] in_key;
	assign value_ext = 64'(value);
	assign in_key = {~value_ext[VALUE_BITS-1], value_ext[VALUE_BITS-2:0]};

	logic [CW-1:0] parent, left_c, right_c;
	logic [CW:0]   left_w;
	assign parent  = (cur_q - CW'(1)) >> 1;
	assign left_w  = {cur_q, 1'b1};
	assign left_c  = left_w[CW-1:0];
	assign right_c = left_c + CW'(1);

	logic left_ok, right_ok;
	assign left_ok  = ({1'b0, left_w} < {2'b0, hcnt_q});
	assign right_ok = ({1'b0, left_w} + (CW+2)'(1) < {2'b0, hcnt_q});

	// best child is picked in the step after both reads
	logic [VALUE_BITS-1:0] best_v;
	logic [CW-1:0]         best_i;
	always_comb begin
		if (right_ok && h_rd > kid_a_q) begin
			best_v = h_rd;
			best_i = right_c;
		end else begin
			best_v = kid_a_q;
			best_i = left_c;
		end
	end

	// RAM port control
	always_comb begin
		l_we = cmd.push_wr;
		f_we = cmd.push_wr;
		l_addr = cmd.push_wr ? cnt_q[AW-1:0] : AW'(cnt_q - CW'(1));
		f_addr = cmd.push_wr ? tail_q : head_q;
		h_we = 1'b0;
		h_wd = hold_q;
		h_addr = cur_q[AW-1:0];
		if (cmd.heap_rd_up) begin
			h_addr = parent[AW-1:0];
		end else if (cmd.heap_up_step && !sts.up_done) begin
			h_we = 1'b1; h_wd = h_rd;
		end else if (cmd.heap_pop_start) begin
			h_addr = AW'(cnt_q - CW'(1));
		end else if (cmd.heap_rd_kids) begin
			h_addr = kid_phase_q ? right_c[AW-1:0] : left_c[AW-1:0];
		end else if (cmd.heap_dn_step && !sts.dn_done) begin
			h_we = 1'b1; h_wd = best_v;
		end else if (cmd.heap_place) begin
			h_we = 1'b1;
		end
	end

	always_comb begin
		sts.req       = req_q;
		sts.full      = (cnt_q == CW'(STORE_DEPTH));
		sts.empty     = (cnt_q == '0);
		sts.up_done   = (cur_q == '0) || (h_rd >= hold_q);
		sts.dn_done   = !left_ok || (best_v <= hold_q);
		sts.heap_last = (cnt_q == CW'(1));
	end

	assign verdict    = verdict_of(may_l_q, may_f_q, may_h_q);
	assign overflowed = ovf_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_key;
		end
		// left child data arrives while the right child is addressed
		if (cmd.heap_rd_kids && kid_phase_q) begin
			kid_a_q <= h_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= REQ_NONE;
			cnt_q <= '0; head_q <= '0; tail_q <= '0;
			cur_q <= '0; hcnt_q <= '0; hold_q <= '0;
			may_l_q <= 1'b1; may_f_q <= 1'b1; may_h_q <= 1'b1; ovf_q <= 1'b0;
			kid_phase_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				req_q <= req_type;
				if (req_type == REQ_PUSH && cnt_q == CW'(STORE_DEPTH)) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.push_wr) begin
				tail_q <= (tail_q == AW'(STORE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
				cur_q  <= cnt_q;
				hold_q <= key_q;
				cnt_q  <= cnt_q + CW'(1);
			end
			if (cmd.heap_up_step && !sts.up_done) begin
				cur_q <= parent;
			end
			if (cmd.pop_empty) begin
				may_l_q <= 1'b0; may_f_q <= 1'b0; may_h_q <= 1'b0;
			end
			if (cmd.pop_chk) begin
				head_q <= (head_q == AW'(STORE_DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			// heap_pop_start follows a cycle where lifo/fifo/heap root were read
			if (cmd.heap_pop_start) begin
				if (l_rd != key_q) may_l_q <= 1'b0;
				if (f_rd != key_q) may_f_q <= 1'b0;
				if (h_rd != key_q) may_h_q <= 1'b0;
				cnt_q  <= cnt_q - CW'(1);
				hcnt_q <= cnt_q - CW'(1);
				cur_q  <= '0;
			end
			if (cmd.heap_rd_kids) begin
				kid_phase_q <= !kid_phase_q;
			end
			if (cmd.heap_dn_step && !sts.dn_done) begin
				cur_q <= best_i;
			end
			if (cmd.clear) begin
				cnt_q <= '0; head_q <= '0; tail_q <= '0;
				may_l_q <= 1'b1; may_f_q <= 1'b1; may_h_q <= 1'b1; ovf_q <= 1'b0;
			end
			if (cmd.heap_place) begin
				kid_phase_q <= 1'b0;
				cur_q <= '0;
			end
			// last entry of the heap is on read data in the cycle after heap_pop_start
			if (hold_load_q) begin
				hold_q <= h_rd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_load_q <= 1'b0;
		end else begin
			hold_load_q <= cmd.heap_pop_start;
		end
	end
endmodule

// ===== src/lfptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfptc_ctrl: sequencing state machine
// Steps one transaction at a time through push, pop and finish sequences.
// ----------------------------------------------------------------------------
module lfptc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  lfptc_pkg::lfptc_sts_t sts,
	output lfptc_pkg::lfptc_cmd_t cmd
);
	import lfptc_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DEC    = 4'd1;
	localparam logic [3:0] ST_UP_RD  = 4'd2;
	localparam logic [3:0] ST_UP_CMP = 4'd3;
	localparam logic [3:0] ST_POP_RD = 4'd4;
	localparam logic [3:0] ST_POP_CK = 4'd5;
	localparam logic [3:0] ST_LAST   = 4'd6;
	localparam logic [3:0] ST_KID_A  = 4'd7;
	localparam logic [3:0] ST_KID_B  = 4'd8;
	localparam logic [3:0] ST_DN_CMP = 4'd9;
	localparam logic [3:0] ST_PLACE  = 4'd10;
	localparam logic [3:0] ST_OUT    = 4'd11;

	logic [3:0] state_q, state_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				unique case (sts.req)
					REQ_PUSH: begin
						if (sts.full) begin
							state_d = ST_IDLE;
						end else begin
							cmd.push_wr = 1'b1;
							state_d = ST_UP_RD;
						end
					end
					REQ_POP: begin
						if (sts.empty) begin
							cmd.pop_empty = 1'b1;
							state_d = ST_IDLE;
						end else begin
							state_d = ST_POP_RD;
						end
					end
					REQ_FINISH: state_d = ST_OUT;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_UP_RD: begin
				cmd.heap_rd_up = 1'b1;
				state_d = ST_UP_CMP;
			end
			ST_UP_CMP: begin
				cmd.heap_up_step = 1'b1;
				state_d = sts.up_done ? ST_PLACE : ST_UP_RD;
			end
			ST_POP_RD: begin
				// RAMs read lifo top, fifo head, heap root (cursor zero)
				state_d = ST_POP_CK;
			end
			ST_POP_CK: begin
				cmd.pop_chk = 1'b1;
				cmd.heap_pop_start = 1'b1;
				state_d = sts.heap_last ? ST_IDLE : ST_LAST;
			end
			ST_LAST: begin
				// last entry is on read data; latched as held key
				state_d = ST_KID_A;
			end
			ST_KID_A: begin
				cmd.heap_rd_kids = 1'b1;
				state_d = ST_KID_B;
			end
			ST_KID_B: begin
				cmd.heap_rd_kids = 1'b1;
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				cmd.heap_dn_step = 1'b1;
				state_d = sts.dn_done ? ST_PLACE : ST_KID_A;
			end
			ST_PLACE: begin
				cmd.heap_place = 1'b1;
				state_d = ST_IDLE;
			end
			ST_OUT: begin
				if (!out_stall) begin
					cmd.clear = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== src/lifo_fifo_priority_trace_checker.sv =====
// ----------------------------------------------------------------------------
// lifo_fifo_priority_trace_checker: push/pop trace classifier
// Mirrors a push/pop trace into a stack, a queue and a max-heap and reports
// which of them could have produced it.
// ----------------------------------------------------------------------------
// One transaction at a time: in_stall stays high from acceptance until the
// controller is back in idle. A push writes the stores and then lets the new
// key rise through the heap, one level per read and write back; a pop checks
// the lifo top, fifo head and heap root, then lets the moved key sink at most
// log2(STORE_DEPTH) levels, or ends there when it empties the stores. A push
// to full stores, a pop on empty stores and an ignored request end after decode.
// The single-port heap RAM sets this pace: each sift level needs its reads and
// a write back. A finish transaction holds its verdict on the output until it
// is taken, then empties the stores. Stores need no clearing pass after reset.
module lifo_fifo_priority_trace_checker #(
	parameter int STORE_DEPTH = lfptc_pkg::DEF_STORE_DEPTH,
	parameter int VALUE_BITS  = lfptc_pkg::DEF_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic signed [lfptc_pkg::IN_VALUE_BITS-1:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  verdict,
	output logic        overflowed
);
	import lfptc_pkg::*;

	lfptc_cmd_t cmd;
	lfptc_sts_t sts;

	// controller: sequences each transaction
	lfptc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd));

	// datapath: RAMs, counts, heap cursor, flags
	lfptc_datapath #(.STORE_DEPTH(STORE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req_type(req_type), .value(value),
		.cmd(cmd), .sts(sts),
		.verdict(verdict), .overflowed(overflowed));
endmodule
